/* rtl/core/psu_pkg.sv */
// shared types and constants of the png scanline unfilter
`default_nettype none

package psu_pkg;

  // fixed field widths
  localparam int ROW_W      = 18;
  localparam int PIX_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 1'b1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } psu_filt_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       pass_start;
  } psu_in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;
  } psu_out_t;

  // one item handed from the row control to the reconstruction stage
  typedef struct packed {
    logic [7:0] data;
    psu_filt_t  kind;
    logic       use_left;
    logic       first_row;
    logic       last;
    logic       bad;
  } psu_item_t;

endpackage

`default_nettype wire

/* rtl/core/psu_line_mem.sv */
// line store holding the previous reconstructed row, with write-to-read forwarding
`default_nettype none

module psu_line_mem #(
  parameter int MAX_ROW_BYTES = 131072
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              rd_en,
  input  wire logic [$clog2(MAX_ROW_BYTES)-1:0]  rd_addr,
  output logic      [7:0]                        rd_data,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(MAX_ROW_BYTES)-1:0]  wr_addr,
  input  wire logic [7:0]                        wr_data
);

  logic [7:0] mem [MAX_ROW_BYTES];
  logic [7:0] rdata_r;
  logic [7:0] fwd_data_r;
  logic       fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // same-edge write to the address being read: hand the new byte on
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rdata_r;

  a_fwd_read : assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en && (rd_addr == wr_addr) |=> rd_data == $past(wr_data))
    else $error("line store read missed a same-cycle write");

endmodule

`default_nettype wire

/* rtl/core/psu_ctrl.sv */
// row control: filter byte decode, byte position, first row and error hold
`default_nettype none

module psu_ctrl #(
  parameter int MAX_ROW_BYTES   = 131072,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire psu_pkg::psu_in_t                        in_data,
  input  wire logic [$clog2(MAX_ROW_BYTES+1)-1:0]      row_len,
  input  wire logic [$clog2(MAX_PIXEL_BYTES+1)-1:0]    pix_len,
  input  wire logic                                    stage_ready,
  output logic                                         issue,
  output psu_pkg::psu_item_t                           item,
  output logic [$clog2(MAX_ROW_BYTES)-1:0]             item_addr,
  output logic                                         rd_en
);

  import psu_pkg::*;

  localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic             first_r, first_nxt, first_eff;
  logic             err_r, err_nxt, err_eff;
  psu_filt_t        kind_r, kind_nxt;
  logic [POS_W-1:0] idx_raw, idx;
  logic             last;
  logic             make_item;
  logic             in_xfer;

  assign in_stall = !stage_ready;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    pos_eff   = in_data.pass_start ? '0 : pos_r;
    first_eff = in_data.pass_start ? 1'b1 : first_r;
    err_eff   = in_data.pass_start ? 1'b0 : err_r;

    // position clamps to the row when row_bytes shrank under us
    idx_raw = pos_eff - POS_W'(1);
    idx     = (idx_raw >= row_len) ? row_len - POS_W'(1) : idx_raw;
    last    = ({1'b0, idx} + (POS_W+1)'(1)) >= {1'b0, row_len};

    make_item      = 1'b0;
    item.data      = in_data.data_byte;
    item.kind      = kind_r;
    item.use_left  = idx >= POS_W'(pix_len);
    item.first_row = first_eff;
    item.last      = last;
    item.bad       = 1'b0;

    pos_nxt   = pos_eff;
    first_nxt = first_eff;
    err_nxt   = err_eff;
    kind_nxt  = kind_r;

    if (!err_eff) begin
      if (pos_eff == '0) begin
        if (in_data.data_byte > 8'(FILT_PAETH)) begin
          make_item = 1'b1;
          item.bad  = 1'b1;
          err_nxt   = 1'b1;
        end else begin
          kind_nxt = psu_filt_t'(in_data.data_byte[2:0]);
          pos_nxt  = POS_W'(1);
        end
      end else begin
        make_item = 1'b1;
        if (last) begin
          pos_nxt   = '0;
          first_nxt = 1'b0;
        end else begin
          pos_nxt = idx + POS_W'(2);
        end
      end
    end
  end

  assign issue     = in_xfer && make_item;
  assign item_addr = idx[ADDR_W-1:0];
  assign rd_en     = issue && !item.bad && !first_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      first_r <= 1'b1;
      err_r   <= 1'b0;
      kind_r  <= FILT_NONE;
    end else if (in_xfer) begin
      pos_r   <= pos_nxt;
      first_r <= first_nxt;
      err_r   <= err_nxt;
      kind_r  <= kind_nxt;
    end
  end

  a_hold_drops : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && err_r && !in_data.pass_start |-> !issue)
    else $error("item issued while error hold set");

  a_bad_sets_hold : assert property (@(posedge clk) disable iff (!rst_n)
    issue && item.bad |=> err_r)
    else $error("bad filter did not set error hold");

  a_first_row_ends : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(first_r) |-> $past(issue && item.last && !item.bad))
    else $error("first row flag cleared without a row end");

endmodule

`default_nettype wire

/* rtl/core/psu_recon.sv */
// reconstruction stage: predictor, left and above-left history, output register
`default_nettype none

module psu_recon #(
  parameter int MAX_ROW_BYTES   = 131072,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    issue,
  input  wire psu_pkg::psu_item_t                      item,
  input  wire logic [$clog2(MAX_ROW_BYTES)-1:0]        item_addr,
  input  wire logic [$clog2(MAX_PIXEL_BYTES+1)-1:0]    pix_len,
  output logic                                         stage_ready,
  input  wire logic [7:0]                              above_byte,
  output logic                                         wr_en,
  output logic [$clog2(MAX_ROW_BYTES)-1:0]             wr_addr,
  output logic [7:0]                                   wr_data,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output psu_pkg::psu_out_t                            out_data
);

  import psu_pkg::*;

  localparam int ADDR_W  = $clog2(MAX_ROW_BYTES);
  localparam int HIST_IW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] da, db, dc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    else if (db <= dc) return b;
    else return c;
  endfunction

  psu_item_t         s1_item_r;
  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_addr_r;
  psu_out_t          out_data_r;
  logic              out_valid_r;
  logic [7:0]        left_hist_r [MAX_PIXEL_BYTES];
  logic [7:0]        uleft_hist_r [MAX_PIXEL_BYTES];

  logic               out_free, s1_go;
  logic [HIST_IW-1:0] hidx;
  logic [7:0]         a, b, c, pred, x;
  logic [8:0]         ab_sum;
  psu_out_t           res;

  assign out_free    = !out_valid_r || !out_stall;
  assign s1_go       = s1_valid_r && out_free;
  assign stage_ready = !s1_valid_r || out_free;

  always_comb begin
    hidx   = HIST_IW'(pix_len - 1'b1);
    a      = s1_item_r.use_left ? left_hist_r[hidx] : 8'd0;
    b      = s1_item_r.first_row ? 8'd0 : above_byte;
    c      = (s1_item_r.use_left && !s1_item_r.first_row) ? uleft_hist_r[hidx] : 8'd0;
    ab_sum = {1'b0, a} + {1'b0, b};
    case (s1_item_r.kind)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
    x = s1_item_r.data + pred;

    if (s1_item_r.bad) begin
      res.pixel_byte = 8'd0;
      res.row_end    = 1'b0;
      res.bad_filter = 1'b1;
    end else begin
      res.pixel_byte = x;
      res.row_end    = s1_item_r.last;
      res.bad_filter = 1'b0;
    end
  end

  assign wr_en   = s1_go && !s1_item_r.bad;
  assign wr_addr = s1_addr_r;
  assign wr_data = x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_item_r <= item;
      s1_addr_r <= item_addr;
    end
    if (s1_go) begin
      out_data_r <= res;
    end
  end

  // history shifts once per rebuilt byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist_r[k]  <= 8'd0;
        uleft_hist_r[k] <= 8'd0;
      end
    end else if (wr_en) begin
      for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
        left_hist_r[k]  <= left_hist_r[k-1];
        uleft_hist_r[k] <= uleft_hist_r[k-1];
      end
      left_hist_r[0]  <= x;
      uleft_hist_r[0] <= b;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> !s1_valid_r || s1_go)
    else $error("held item overwritten in reconstruction stage");

endmodule

`default_nettype wire

/* rtl/core/png_scanline_unfilter.sv */
// top level of the png scanline unfilter
`default_nettype none

// Rebuilds PNG filtered rows from the decompressed byte stream, one byte per transfer.
// The first byte of a row is the filter type and produces no output; each following
// data byte gives one reconstructed byte, with row_end on the last of the row. A filter
// type above four gives a single bad_filter transfer, after which input is swallowed
// until a byte flagged pass_start. The block takes one byte every clock cycle in steady
// state while the output is not stalled: the previous row sits in a single-port-write,
// single-port-read line store of MAX_ROW_BYTES bytes whose read is issued as the byte is
// taken, and the rebuilt byte is written back at the same address, with a forwarding path
// covering a read and write to the same entry in the same cycle. A data byte is held in
// the stage register after its transfer in and then loaded into the output register, from
// which its result transfers out. The line store needs no clearing after reset; the first
// row of every pass reads the row above as zeros. Configuration (row_bytes at index 0,
// pixel_bytes at index 1) may only be written while no byte is in flight; out-of-range
// values are clamped to the legal range, pixel_bytes after keeping its low four bits.

module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES   = 131072,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input byte stream
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire psu_pkg::psu_in_t                    in_data,
  // reconstructed bytes
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output psu_pkg::psu_out_t                        out_data,
  // configuration writes
  input  wire logic                                cfg_we,
  input  wire logic [psu_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [psu_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import psu_pkg::*;

  localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int PB_W   = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

  logic [ROW_W-1:0]  row_bytes_r;
  logic [PIX_W-1:0]  pixel_bytes_r;
  logic [POS_W-1:0]  row_len;
  logic [PB_W-1:0]   pix_len;

  logic              stage_ready;
  logic              issue;
  psu_item_t         item;
  logic [ADDR_W-1:0] item_addr;
  logic              rd_en;
  logic [7:0]        above_byte;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  // configuration registers, raw as written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r   <= ROW_W'(1);
      pixel_bytes_r <= PIX_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROW_BYTES:   row_bytes_r   <= cfg_wdata[ROW_W-1:0];
        REG_PIXEL_BYTES: pixel_bytes_r <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to 1..max so zero and oversize values behave
  always_comb begin
    if (row_bytes_r == '0) begin
      row_len = POS_W'(1);
    end else if (row_bytes_r > ROW_W'(MAX_ROW_BYTES)) begin
      row_len = POS_W'(MAX_ROW_BYTES);
    end else begin
      row_len = POS_W'(row_bytes_r);
    end
    if (pixel_bytes_r == '0) begin
      pix_len = PB_W'(1);
    end else if (pixel_bytes_r > PIX_W'(MAX_PIXEL_BYTES)) begin
      pix_len = PB_W'(MAX_PIXEL_BYTES);
    end else begin
      pix_len = PB_W'(pixel_bytes_r);
    end
  end

  // filter byte decode and row position
  psu_ctrl #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .row_len     (row_len),
    .pix_len     (pix_len),
    .stage_ready (stage_ready),
    .issue       (issue),
    .item        (item),
    .item_addr   (item_addr),
    .rd_en       (rd_en)
  );

  // previous row
  psu_line_mem #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_line_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (item_addr),
    .rd_data (above_byte),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // predictor and output register
  psu_recon #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_recon (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue       (issue),
    .item        (item),
    .item_addr   (item_addr),
    .pix_len     (pix_len),
    .stage_ready (stage_ready),
    .above_byte  (above_byte),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

/* tb/psu_unfilter_check.sv */
// checker for the png scanline unfilter: rebuilds each byte and compares the results
module psu_unfilter_check #(
  parameter int MAX_ROW_BYTES   = 131072,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  psu_pkg::psu_in_t                    in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  psu_pkg::psu_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [psu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output int                                  in_flight,
  output int                                  fails
);
  import psu_pkg::*;

  // own copy of the block state
  logic [7:0]       prev_row [MAX_ROW_BYTES];
  logic [7:0]       left_hist [MAX_PIXEL_BYTES];
  logic [7:0]       above_hist [MAX_PIXEL_BYTES];
  psu_filt_t        kind;
  int               pos;
  bit               first_row;
  bit               halted;
  logic [ROW_W-1:0] row_len;
  logic [PIX_W-1:0] px_len;

  psu_out_t rebuilt_q[$];
  psu_out_t want;

  function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int p, da, db, dc;
    p  = int'(a) + int'(b) - int'(c);
    da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  task automatic rebuild_byte(input psu_in_t item);
    int         rb, pb, idx, k;
    logic [7:0] a, b, c, pred, x;
    psu_out_t   res;
    rb = (row_len == 0) ? 1 : ((int'(row_len) > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(row_len));
    pb = (px_len == 0) ? 1 : ((int'(px_len) > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : int'(px_len));
    res = '0;
    if (item.pass_start) begin
      pos = 0;
      first_row = 1'b1;
      halted = 1'b0;
      for (k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist[k] = 8'd0;
        above_hist[k] = 8'd0;
      end
    end
    if (halted) return;
    if (pos == 0) begin
      if (item.data_byte > 8'(FILT_PAETH)) begin
        halted = 1'b1;
        res.bad_filter = 1'b1;
        rebuilt_q.push_back(res);
      end else begin
        kind = psu_filt_t'(item.data_byte[2:0]);
        pos = 1;
      end
      return;
    end
    idx = pos - 1;
    if (idx >= rb) idx = rb - 1;
    a = (idx >= pb) ? left_hist[pb-1] : 8'd0;
    b = first_row ? 8'd0 : prev_row[idx];
    c = (idx >= pb && !first_row) ? above_hist[pb-1] : 8'd0;
    case (kind)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 8'd0;
    endcase
    x = item.data_byte + pred;
    prev_row[idx] = x;
    for (k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
      left_hist[k] = left_hist[k-1];
      above_hist[k] = above_hist[k-1];
    end
    left_hist[0] = x;
    above_hist[0] = b;
    res.pixel_byte = x;
    res.row_end = (idx + 1 >= rb);
    if (res.row_end) begin
      pos = 0;
      first_row = 1'b0;
    end else begin
      pos = idx + 2;
    end
    rebuilt_q.push_back(res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist[k] = 8'd0;
        above_hist[k] = 8'd0;
      end
      kind = FILT_NONE;
      pos = 0;
      first_row = 1'b1;
      halted = 1'b0;
      row_len = ROW_W'(1);
      px_len = PIX_W'(1);
      rebuilt_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_ROW_BYTES) row_len = cfg_wdata[ROW_W-1:0];
        else if (cfg_idx == REG_PIXEL_BYTES) px_len = cfg_wdata[PIX_W-1:0];
      end
      if (in_valid && !in_stall) rebuild_byte(in_data);
      if (out_valid && !out_stall) begin
        if (rebuilt_q.size() == 0) begin
          $error("unexpected transfer: pixel_byte %0d row_end %0d bad_filter %0d",
                 out_data.pixel_byte, out_data.row_end, out_data.bad_filter);
          fails++;
        end else begin
          want = rebuilt_q.pop_front();
          if (out_data.pixel_byte !== want.pixel_byte) begin
            $error("pixel_byte: expected %0d, got %0d", want.pixel_byte, out_data.pixel_byte);
            fails++;
          end
          if (out_data.row_end !== want.row_end) begin
            $error("row_end: expected %0d, got %0d", want.row_end, out_data.row_end);
            fails++;
          end
          if (out_data.bad_filter !== want.bad_filter) begin
            $error("bad_filter: expected %0d, got %0d", want.bad_filter, out_data.bad_filter);
            fails++;
          end
        end
      end
    end
    in_flight = rebuilt_q.size();
  end

endmodule

/* tb/tb_png_scanline_unfilter.sv */
// top of the png scanline unfilter testbench: clock, reset, byte stream and verdict
module tb_png_scanline_unfilter;
  import psu_pkg::*;

  localparam int MAX_ROW_BYTES   = 131072;
  localparam int MAX_PIXEL_BYTES = 8;
  // a data byte passes the stage and output registers to reach the output, a filter byte gives nothing
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_CYCLES     = 80;
  localparam int TARGET_BYTES    = 800;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  psu_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  psu_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_ROW_BYTES;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int in_flight;
  int mismatches;

  // idling odds in percent, changed per phase by the stimulus
  int send_gap_pct = 0;
  int stall_pct = 0;
  // long receiver hold-off: the stimulus bumps the request count, the stall process counts
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #1 clk = ~clk;

  png_scanline_unfilter #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  psu_unfilter_check #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_flight (in_flight),
    .fails     (mismatches)
  );

  // receiver side: random stalls, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // offer one byte and return at the falling edge after its transfer;
  // valid stays high so the caller either offers the next byte or drops it
  task automatic push_byte(input logic [7:0] data, input logic first);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: data, pass_start: first};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending and wait for every expected byte, then for the pipeline to empty
  task automatic settle();
    in_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] row_cfg;
    logic [CFG_DATA_W-1:0] pix_cfg;
    int                    fed;
    int                    row_eff;
    int                    rows;
    int                    n_send;
    bit                    pass_over;
    logic [7:0]            ftype;

    fed = 0;
    row_cfg = 1;
    pix_cfg = 1;

    // reset held low at the start, then released
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: two-byte rows through every filter type, with data extremes
    cfg_write(REG_ROW_BYTES, 2);
    cfg_write(REG_PIXEL_BYTES, 1);
    push_byte(8'(FILT_NONE), 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'(FILT_SUB), 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'(FILT_UP), 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'(FILT_AVG), 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'(FILT_PAETH), 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'hFF, 1'b0);
    // bad filter type, a swallowed byte, then the largest bad type on a new pass
    push_byte(8'd5, 1'b1);
    push_byte(8'h33, 1'b0);
    push_byte(8'hFF, 1'b1);

    // registers beyond range clamp; the row length is cut short mid-row
    settle();
    cfg_write(REG_ROW_BYTES, '1);
    cfg_write(REG_PIXEL_BYTES, CFG_DATA_W'(4'hF));
    push_byte(8'(FILT_SUB), 1'b1);
    push_byte(8'h10, 1'b0);
    push_byte(8'h20, 1'b0);
    push_byte(8'h30, 1'b0);
    settle();
    cfg_write(REG_ROW_BYTES, 2);
    row_cfg = 2;
    pix_cfg = 4'hF;
    // position has already passed the new length, so this byte closes the row
    push_byte(8'h40, 1'b0);
    push_byte(8'(FILT_PAETH), 1'b0);
    push_byte(8'h9A, 1'b0);
    push_byte(8'hC5, 1'b0);
    settle();

    // long receiver hold-off while bytes keep coming, so the block backs up
    hold_asks++;
    for (int r = 0; r < 6; r++) begin
      push_byte(8'(r % 5), r == 0);
      repeat (2) push_byte(8'($urandom_range(255)), 1'b0);
    end
    settle();

    // random passes: well-formed rows with random content, some bad types and cut rows
    while (fed < TARGET_BYTES) begin
      case ((fed / 160) % 5)
        1:       begin send_gap_pct = 57; stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  stall_pct = 57; end
        3:       begin send_gap_pct = 28; stall_pct = 28; end
        default: begin send_gap_pct = 0;  stall_pct = 0;  end
      endcase

      // new settings only between passes, with nothing in flight
      if (fed == 0 || $urandom_range(1) == 0) begin
        settle();
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(19))
            0:       row_cfg = 0;
            1:       row_cfg = 1;
            2:       row_cfg = CFG_DATA_W'(MAX_ROW_BYTES);
            3:       row_cfg = '1;
            4:       row_cfg = CFG_DATA_W'($urandom_range(2**CFG_DATA_W - 1, MAX_ROW_BYTES + 1));
            5, 6:    row_cfg = CFG_DATA_W'($urandom_range(64, 17));
            default: row_cfg = CFG_DATA_W'($urandom_range(16, 2));
          endcase
          cfg_write(REG_ROW_BYTES, row_cfg);
        end
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(9))
            0:       pix_cfg = 0;
            1:       pix_cfg = CFG_DATA_W'($urandom_range(15, MAX_PIXEL_BYTES + 1));
            default: pix_cfg = CFG_DATA_W'($urandom_range(MAX_PIXEL_BYTES, 1));
          endcase
          cfg_write(REG_PIXEL_BYTES, pix_cfg);
        end
      end

      // the row length the block works with; very long rows are only started
      row_eff = (row_cfg == 0) ? 1 :
                ((int'(row_cfg) > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(row_cfg));
      rows = $urandom_range(5, 1);
      pass_over = 1'b0;
      for (int r = 0; r < rows && !pass_over; r++) begin
        if ($urandom_range(9) == 0) ftype = 8'($urandom_range(255, 5));
        else ftype = 8'($urandom_range(4, 0));
        push_byte(ftype, r == 0);
        fed++;
        if (ftype > 8'(FILT_PAETH)) begin
          // the rest of the pass is swallowed
          repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)), 1'b0);
          pass_over = 1'b1;
        end else begin
          if (row_eff > 64) n_send = $urandom_range(24, 1);
          else if ($urandom_range(11) == 0) n_send = $urandom_range(row_eff - 1, 0);
          else n_send = row_eff;
          repeat (n_send) begin
            push_byte(8'($urandom_range(255)), 1'b0);
            fed++;
          end
          // a cut row ends the pass, later rows would read unwritten bytes above
          if (n_send < row_eff) pass_over = 1'b1;
        end
      end
    end

    in_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
